@@ src/link_receiver_protocol_fsm_defines.svh @@
// ----------------------------------------------------------------------------
// Link receiver assertion macros
// Concurrent assertion helpers for the link receiver RTL.
// ----------------------------------------------------------------------------
`ifndef LINK_RECEIVER_PROTOCOL_FSM_DEFINES_SVH
`define LINK_RECEIVER_PROTOCOL_FSM_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("link receiver assertion failed");
// next-cycle implication
`define LRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("link receiver assertion failed");
`else
`define LRP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/lrp_pkg.sv @@
// ----------------------------------------------------------------------------
// Link receiver package
// Types, codes and sizes shared by the link receiver modules.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int HEADER_LEN    = 50;
  localparam int DIRECTORY_LEN = 50;

  localparam logic [7:0] CHR_P = 8'h50;
  localparam logic [7:0] CHR_1 = 8'h31;
  localparam logic [7:0] CHR_Z = 8'h5A;
  localparam logic [7:0] CHR_D = 8'h44;

  localparam int          PX_SHIFT  = 3;
  localparam logic [15:0] SIZE_BIAS = 16'd2;
  localparam logic [15:0] MIN_SIZE  = 16'd2;

  localparam logic [2:0] RPL_NONE    = 3'd0;
  localparam logic [2:0] RPL_READY   = 3'd1;
  localparam logic [2:0] RPL_ACK     = 3'd2;
  localparam logic [2:0] RPL_AREA    = 3'd3;
  localparam logic [2:0] RPL_GEN_ERR = 3'd4;
  localparam logic [2:0] RPL_SUM_ERR = 3'd5;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_RESP = 3'd1;
  localparam logic [2:0] ERR_HDR_SUM  = 3'd2;
  localparam logic [2:0] ERR_BAD_HDR  = 3'd3;
  localparam logic [2:0] ERR_PRG_SUM  = 3'd4;
  localparam logic [2:0] ERR_DIR_SUM  = 3'd5;
  localparam logic [2:0] ERR_ALL_SUM  = 3'd6;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd7;

  localparam logic [1:0] SECT_PRG = 2'd0;
  localparam logic [1:0] SECT_DIR = 2'd1;
  localparam logic [1:0] SECT_ALL = 2'd2;
  localparam logic [1:0] SECT_SCR = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_ALL  = 2'd2;
  localparam logic [1:0] KIND_SCR  = 2'd3;

  localparam logic [2:0] CFG_SYNC   = 3'd0;
  localparam logic [2:0] CFG_START  = 3'd1;
  localparam logic [2:0] CFG_ACK    = 3'd2;
  localparam logic [2:0] CFG_NAK    = 3'd3;
  localparam logic [2:0] CFG_EXISTS = 3'd4;

  localparam logic [7:0] RST_SYNC  = 8'd22;
  localparam logic [7:0] RST_START = 8'd58;
  localparam logic [7:0] RST_ACK   = 8'd6;
  localparam logic [7:0] RST_NAK   = 8'd21;

  typedef struct packed {
    logic [7:0] sync_code;
    logic [7:0] start_code;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
    logic       target_exists;
  } cfg_t;

  // declared high to low so that reply_code lands in the lowest bits
  typedef struct packed {
    logic [15:0] payload_size;
    logic [7:0]  mode_value;
    logic [1:0]  transfer_kind;
    logic [1:0]  payload_section;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        long_wait;
    logic        finished;
    logic [2:0]  error_kind;
    logic [2:0]  reply_code;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ src/lrp_core.sv @@
// ----------------------------------------------------------------------------
// Link receiver core
// Session state machine: one received byte or timeout per transaction.
// ----------------------------------------------------------------------------
module lrp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             req_type_i,
  input  logic [7:0]       rx_byte_i,
  input  lrp_pkg::cfg_t    cfg_i,
  output lrp_pkg::result_t res_o
);

  typedef enum logic [3:0] {
    PH_WAIT_SYNC,
    PH_WAIT_HDR,
    PH_READ_HDR,
    PH_OVERWRITE,
    PH_WAIT_PRG,
    PH_READ_PRG,
    PH_WAIT_DIR,
    PH_READ_DIR,
    PH_WAIT_ALL,
    PH_READ_ALL,
    PH_WAIT_SCR,
    PH_READ_SCR,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] size_q, size_d;
  logic [7:0]  mode_q, mode_d;
  logic        long_q, long_d;
  logic [7:0]  hdr_q [6];

  logic [7:0]  hdr_view [6];
  logic        hdr_we;
  logic [2:0]  hdr_idx;
  logic [7:0]  sum_inc;
  logic [15:0] count_inc;
  logic [15:0] px;
  logic [15:0] scr_size;
  logic [15:0] prg_size;
  logic [1:0]  dec_kind;
  logic        hdr_ok;

  logic [2:0]  reply;
  logic [2:0]  err;
  logic        pvalid;
  logic [7:0]  pbyte;
  logic [1:0]  psect;

  assign sum_inc   = sum_q + rx_byte_i;
  assign count_inc = count_q + 16'd1;
  assign hdr_we    = (phase_q == PH_READ_HDR) && !req_type_i &&
                     (count_q >= 16'd1) && (count_q <= 16'd6);
  assign hdr_idx   = 3'(count_q[2:0] - 3'd1);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hdr_view[i] = (hdr_we && (hdr_idx == 3'(i))) ? rx_byte_i : hdr_q[i];
    end
  end

  assign px       = 16'(hdr_view[2]) * 16'(hdr_view[3]);
  assign scr_size = (px >> lrp_pkg::PX_SHIFT) + lrp_pkg::SIZE_BIAS;
  assign prg_size = {hdr_view[3], hdr_view[4]};

  always_comb begin
    dec_kind = lrp_pkg::KIND_NONE;
    if (hdr_view[0] == lrp_pkg::CHR_P && hdr_view[1] == lrp_pkg::CHR_1) begin
      dec_kind = lrp_pkg::KIND_ONE;
    end else if (hdr_view[0] == lrp_pkg::CHR_P && hdr_view[1] == lrp_pkg::CHR_Z) begin
      dec_kind = lrp_pkg::KIND_ALL;
    end else if (hdr_view[0] == lrp_pkg::CHR_D && hdr_view[1] == lrp_pkg::CHR_D) begin
      dec_kind = lrp_pkg::KIND_SCR;
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    kind_d  = kind_q;
    size_d  = size_q;
    mode_d  = mode_q;
    long_d  = long_q;
    reply   = lrp_pkg::RPL_NONE;
    err     = lrp_pkg::ERR_NONE;
    pvalid  = 1'b0;
    pbyte   = 8'd0;
    psect   = 2'd0;
    hdr_ok  = 1'b0;

    if (req_type_i) begin
      unique case (phase_q) inside
        PH_WAIT_HDR, PH_READ_HDR, PH_WAIT_PRG, PH_READ_PRG,
        PH_WAIT_DIR, PH_READ_DIR, PH_WAIT_ALL, PH_READ_ALL: begin
          phase_d = PH_DONE;
          reply   = lrp_pkg::RPL_GEN_ERR;
          err     = lrp_pkg::ERR_TIMEOUT;
        end
        default: ;
      endcase
    end else begin
      unique case (phase_q)
        PH_WAIT_SYNC: begin
          if (rx_byte_i == cfg_i.sync_code) begin
            phase_d = PH_WAIT_HDR;
            long_d  = 1'b0;
            reply   = lrp_pkg::RPL_READY;
          end else begin
            phase_d = PH_DONE;
            reply   = lrp_pkg::RPL_GEN_ERR;
            err     = lrp_pkg::ERR_BAD_RESP;
          end
        end
        PH_WAIT_HDR: begin
          if (rx_byte_i == cfg_i.start_code) begin
            phase_d = PH_READ_HDR;
            count_d = 16'd1;
            sum_d   = 8'd0;
          end else begin
            phase_d = PH_DONE;
            reply   = lrp_pkg::RPL_GEN_ERR;
            err     = lrp_pkg::ERR_BAD_RESP;
          end
        end
        PH_READ_HDR: begin
          sum_d   = sum_inc;
          count_d = count_inc;
          if (count_inc >= 16'(lrp_pkg::HEADER_LEN)) begin
            if (sum_inc != 8'd0) begin
              phase_d = PH_DONE;
              reply   = lrp_pkg::RPL_SUM_ERR;
              err     = lrp_pkg::ERR_HDR_SUM;
            end else begin
              kind_d = dec_kind;
              if (dec_kind == lrp_pkg::KIND_SCR) begin
                size_d = scr_size;
                hdr_ok = 1'b1;
              end else if (dec_kind != lrp_pkg::KIND_NONE) begin
                size_d = prg_size;
                if (prg_size >= lrp_pkg::MIN_SIZE) begin
                  mode_d = hdr_view[5];
                  hdr_ok = 1'b1;
                end
              end
              if (!hdr_ok) begin
                phase_d = PH_DONE;
                reply   = lrp_pkg::RPL_GEN_ERR;
                err     = lrp_pkg::ERR_BAD_HDR;
              end else if (cfg_i.target_exists) begin
                phase_d = PH_OVERWRITE;
                long_d  = 1'b1;
                reply   = lrp_pkg::RPL_AREA;
              end else begin
                reply = lrp_pkg::RPL_ACK;
                unique case (dec_kind)
                  lrp_pkg::KIND_SCR: phase_d = PH_WAIT_SCR;
                  lrp_pkg::KIND_ALL: phase_d = PH_WAIT_DIR;
                  default:           phase_d = PH_WAIT_PRG;
                endcase
              end
            end
          end
        end
        PH_OVERWRITE: begin
          if (rx_byte_i == cfg_i.ack_code) begin
            long_d = 1'b0;
            unique case (kind_q)
              lrp_pkg::KIND_ONE: begin
                phase_d = PH_WAIT_PRG;
                reply   = lrp_pkg::RPL_ACK;
              end
              lrp_pkg::KIND_ALL: begin
                phase_d = PH_WAIT_DIR;
                reply   = lrp_pkg::RPL_ACK;
              end
              default: begin
                phase_d = PH_DONE;
                reply   = lrp_pkg::RPL_GEN_ERR;
                err     = lrp_pkg::ERR_BAD_HDR;
              end
            endcase
          end else if (rx_byte_i == cfg_i.nak_code) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_DONE;
            reply   = lrp_pkg::RPL_GEN_ERR;
            err     = lrp_pkg::ERR_BAD_RESP;
          end
        end
        PH_WAIT_PRG, PH_WAIT_DIR, PH_WAIT_ALL, PH_WAIT_SCR: begin
          if (rx_byte_i != cfg_i.start_code) begin
            phase_d = PH_DONE;
            reply   = lrp_pkg::RPL_GEN_ERR;
            err     = lrp_pkg::ERR_BAD_RESP;
          end else begin
            count_d = 16'd1;
            sum_d   = 8'd0;
            pvalid  = 1'b1;
            pbyte   = rx_byte_i;
            unique case (phase_q)
              PH_WAIT_PRG: begin
                phase_d = PH_READ_PRG;
                psect   = lrp_pkg::SECT_PRG;
              end
              PH_WAIT_DIR: begin
                phase_d = PH_READ_DIR;
                psect   = lrp_pkg::SECT_DIR;
              end
              PH_WAIT_ALL: begin
                phase_d = PH_READ_ALL;
                psect   = lrp_pkg::SECT_ALL;
              end
              default: begin
                phase_d = PH_READ_SCR;
                psect   = lrp_pkg::SECT_SCR;
              end
            endcase
          end
        end
        PH_READ_PRG, PH_READ_SCR, PH_READ_ALL: begin
          sum_d   = sum_inc;
          count_d = count_inc;
          pvalid  = 1'b1;
          pbyte   = rx_byte_i;
          unique case (phase_q)
            PH_READ_PRG: psect = lrp_pkg::SECT_PRG;
            PH_READ_ALL: psect = lrp_pkg::SECT_ALL;
            default:     psect = lrp_pkg::SECT_SCR;
          endcase
          if (count_inc >= size_q) begin
            phase_d = PH_DONE;
            if (sum_inc != 8'd0) begin
              reply = lrp_pkg::RPL_SUM_ERR;
              err   = (phase_q == PH_READ_ALL) ? lrp_pkg::ERR_ALL_SUM
                                               : lrp_pkg::ERR_PRG_SUM;
            end else begin
              reply = lrp_pkg::RPL_ACK;
            end
          end
        end
        PH_READ_DIR: begin
          sum_d   = sum_inc;
          count_d = count_inc;
          pvalid  = 1'b1;
          pbyte   = rx_byte_i;
          psect   = lrp_pkg::SECT_DIR;
          if (count_inc >= 16'(lrp_pkg::DIRECTORY_LEN)) begin
            if (sum_inc != 8'd0) begin
              phase_d = PH_DONE;
              reply   = lrp_pkg::RPL_SUM_ERR;
              err     = lrp_pkg::ERR_DIR_SUM;
            end else begin
              phase_d = PH_WAIT_ALL;
              reply   = lrp_pkg::RPL_ACK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o                 = '0;
    res_o.reply_code      = reply;
    res_o.error_kind      = err;
    res_o.finished        = (phase_d == PH_DONE);
    res_o.long_wait       = long_d;
    res_o.payload_valid   = pvalid;
    res_o.payload_byte    = pbyte;
    res_o.payload_section = psect;
    res_o.transfer_kind   = kind_d;
    res_o.mode_value      = mode_d;
    res_o.payload_size    = size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_SYNC;
      count_q <= 16'd0;
      sum_q   <= 8'd0;
      kind_q  <= lrp_pkg::KIND_NONE;
      size_q  <= 16'd0;
      mode_q  <= 8'd0;
      long_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      kind_q  <= kind_d;
      size_q  <= size_d;
      mode_q  <= mode_d;
      long_q  <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && hdr_we) begin
      hdr_q[hdr_idx] <= rx_byte_i;
    end
  end

endmodule

@@ src/link_receiver_protocol_fsm.sv @@
// ----------------------------------------------------------------------------
// Link receiver protocol FSM
// Receiver side of a serial program-link session: sync, header, optional
// overwrite decision, directory and data blocks, with sum checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transaction per received byte (tuser low) or per
//   timeout event (tuser high). m_axis returns exactly one result per input
//   transaction: reply code, error kind, session status and forwarded block
//   byte. cfg_* writes the code and overwrite registers and is always ready;
//   the user must write it only while the block is idle; the block itself
//   does not enforce this. The result of an accepted transaction is
//   registered and valid from the next cycle. Throughput is one transaction
//   per cycle while m_axis takes results, set by the core state update and
//   the one-deep result register, refilled in the same cycle it is taken.
//   When m_axis stalls with a result pending, s_axis_tready drops until the
//   result is taken; nothing is lost or repeated.
//   Reset returns the session to waiting for sync, clears the counters and
//   decoded header values, restores the register defaults and empties the
//   result register. Header bytes are not cleared; they are always written
//   before they are decoded.
// ----------------------------------------------------------------------------
`include "link_receiver_protocol_fsm_defines.svh"

module link_receiver_protocol_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // rx_byte
  input  logic                        s_axis_tuser,  // req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // reply_code, error_kind, finished, long_wait, payload_valid, payload_byte,
  // payload_section, transfer_kind, mode_value, payload_size, zero fill
  output logic [lrp_pkg::TDATA_W-1:0] m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  lrp_pkg::cfg_t    cfg_q;
  lrp_pkg::result_t res_d;
  lrp_pkg::result_t res_q;
  logic             out_valid_q;
  logic             take;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lrp_pkg::TDATA_W - lrp_pkg::RESULT_W){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_code     <= lrp_pkg::RST_SYNC;
      cfg_q.start_code    <= lrp_pkg::RST_START;
      cfg_q.ack_code      <= lrp_pkg::RST_ACK;
      cfg_q.nak_code      <= lrp_pkg::RST_NAK;
      cfg_q.target_exists <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lrp_pkg::CFG_SYNC:   cfg_q.sync_code     <= cfg_data_i;
        lrp_pkg::CFG_START:  cfg_q.start_code    <= cfg_data_i;
        lrp_pkg::CFG_ACK:    cfg_q.ack_code      <= cfg_data_i;
        lrp_pkg::CFG_NAK:    cfg_q.nak_code      <= cfg_data_i;
        lrp_pkg::CFG_EXISTS: cfg_q.target_exists <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lrp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .req_type_i (s_axis_tuser),
    .rx_byte_i  (s_axis_tdata),
    .cfg_i      (cfg_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  `LRP_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, take, out_valid_q)
  `LRP_ASSERT_NOW(a_no_overrun, clk_i, rst_ni, out_valid_q && !m_axis_tready, !s_axis_tready)
  `LRP_ASSERT_NOW(a_idle_payload_zero, clk_i, rst_ni, out_valid_q && !res_q.payload_valid, res_q.payload_byte == 8'd0 && res_q.payload_section == 2'd0)

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Link receiver protocol FSM testbench
// Runs one full link session through the receiver, picking at random a single
// program, an all-programs transfer with directory, or a screen dump, the
// program kinds with or without the overwrite decision step. Each transaction
// is checked against a cycle-free session model in the scoreboard. Register settings
// change between phases, and the session ends on a good or a bad data sum or
// on a timeout. Bursty input and a stalling result side vary the timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lrp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    PH_SYNC, PH_HDR_WAIT, PH_HDR, PH_OVERWRITE, PH_PRG_WAIT, PH_PRG,
    PH_DIR_WAIT, PH_DIR, PH_ALL_WAIT, PH_ALL, PH_SCR_WAIT, PH_SCR, PH_DONE
  } link_phase_e;

  class link_session_tracker;
    logic [7:0]  sync_c, start_c, ack_c, nak_c;
    logic        target_set;
    link_phase_e ph;
    logic [15:0] count, blk_len;
    logic [7:0]  running, mode;
    logic [7:0]  hdr [6];
    logic [1:0]  kind;
    logic        wait_long;
    result_t     now;
    result_t     due_replies [$];
    int          taken;
    int          mismatches;

    function new();
      sync_c     = RST_SYNC;
      start_c    = RST_START;
      ack_c      = RST_ACK;
      nak_c      = RST_NAK;
      target_set = 1'b0;
      ph         = PH_SYNC;
      count      = '0;
      blk_len    = '0;
      running    = '0;
      mode       = '0;
      kind       = KIND_NONE;
      wait_long  = 1'b0;
      taken      = 0;
      mismatches = 0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function void configure(logic [2:0] idx, logic [7:0] val);
      case (idx)
        CFG_SYNC:   sync_c = val;
        CFG_START:  start_c = val;
        CFG_ACK:    ack_c = val;
        CFG_NAK:    nak_c = val;
        CFG_EXISTS: target_set = val[0];
        default: ;
      endcase
    endfunction

    function void halt(logic [2:0] reply, logic [2:0] err);
      ph = PH_DONE;
      now.reply_code = reply;
      now.error_kind = err;
    endfunction

    function bit decode();
      int unsigned px;
      kind = KIND_NONE;
      if (hdr[0] == CHR_P && hdr[1] == CHR_1) kind = KIND_ONE;
      else if (hdr[0] == CHR_P && hdr[1] == CHR_Z) kind = KIND_ALL;
      else if (hdr[0] == CHR_D && hdr[1] == CHR_D) kind = KIND_SCR;
      if (kind == KIND_NONE) return 1'b0;
      if (kind == KIND_SCR) begin
        px = hdr[2] * hdr[3];
        blk_len = 16'((px >> PX_SHIFT) + SIZE_BIAS);
        return 1'b1;
      end
      blk_len = {hdr[3], hdr[4]};
      if (blk_len < MIN_SIZE) return 1'b0;
      mode = hdr[5];
      return 1'b1;
    endfunction

    function void to_block();
      if (kind == KIND_ONE) begin
        ph = PH_PRG_WAIT;
        now.reply_code = RPL_ACK;
      end else if (kind == KIND_ALL) begin
        ph = PH_DIR_WAIT;
        now.reply_code = RPL_ACK;
      end else begin
        halt(RPL_GEN_ERR, ERR_BAD_HDR);
      end
    endfunction

    function void begin_block(logic [7:0] b, link_phase_e next, logic [1:0] sect);
      if (b != start_c) begin
        halt(RPL_GEN_ERR, ERR_BAD_RESP);
        return;
      end
      ph = next;
      count = 16'd1;
      running = '0;
      now.payload_valid = 1'b1;
      now.payload_byte = b;
      now.payload_section = sect;
    endfunction

    function bit add_byte(logic [7:0] b, logic [1:0] sect, logic [15:0] len);
      running = running + b;
      count = count + 16'd1;
      now.payload_valid = 1'b1;
      now.payload_byte = b;
      now.payload_section = sect;
      return count >= len;
    endfunction

    function void take_rx(logic tmo, logic [7:0] b);
      now = '0;
      taken++;
      if (tmo) begin
        case (ph)
          PH_HDR_WAIT, PH_HDR, PH_PRG_WAIT, PH_PRG,
          PH_DIR_WAIT, PH_DIR, PH_ALL_WAIT, PH_ALL: halt(RPL_GEN_ERR, ERR_TIMEOUT);
          default: ;
        endcase
      end else begin
        case (ph)
          PH_SYNC: begin
            if (b == sync_c) begin
              ph = PH_HDR_WAIT;
              wait_long = 1'b0;
              now.reply_code = RPL_READY;
            end else begin
              halt(RPL_GEN_ERR, ERR_BAD_RESP);
            end
          end
          PH_HDR_WAIT: begin
            if (b == start_c) begin
              ph = PH_HDR;
              count = 16'd1;
              running = '0;
            end else begin
              halt(RPL_GEN_ERR, ERR_BAD_RESP);
            end
          end
          PH_HDR: begin
            running = running + b;
            if (count >= 1 && count <= 6) hdr[count - 1] = b;
            count = count + 16'd1;
            if (count >= HEADER_LEN) begin
              if (running != 0) halt(RPL_SUM_ERR, ERR_HDR_SUM);
              else if (!decode()) halt(RPL_GEN_ERR, ERR_BAD_HDR);
              else if (target_set) begin
                ph = PH_OVERWRITE;
                wait_long = 1'b1;
                now.reply_code = RPL_AREA;
              end else if (kind == KIND_SCR) begin
                ph = PH_SCR_WAIT;
                now.reply_code = RPL_ACK;
              end else begin
                to_block();
              end
            end
          end
          PH_OVERWRITE: begin
            if (b == ack_c) begin
              wait_long = 1'b0;
              to_block();
            end else if (b == nak_c) begin
              ph = PH_DONE;
            end else begin
              halt(RPL_GEN_ERR, ERR_BAD_RESP);
            end
          end
          PH_PRG_WAIT: begin_block(b, PH_PRG, SECT_PRG);
          PH_DIR_WAIT: begin_block(b, PH_DIR, SECT_DIR);
          PH_ALL_WAIT: begin_block(b, PH_ALL, SECT_ALL);
          PH_SCR_WAIT: begin_block(b, PH_SCR, SECT_SCR);
          PH_PRG, PH_SCR: begin
            if (add_byte(b, ph == PH_PRG ? SECT_PRG : SECT_SCR, blk_len)) begin
              if (running != 0) halt(RPL_SUM_ERR, ERR_PRG_SUM);
              else begin
                ph = PH_DONE;
                now.reply_code = RPL_ACK;
              end
            end
          end
          PH_DIR: begin
            if (add_byte(b, SECT_DIR, 16'(DIRECTORY_LEN))) begin
              if (running != 0) halt(RPL_SUM_ERR, ERR_DIR_SUM);
              else begin
                ph = PH_ALL_WAIT;
                now.reply_code = RPL_ACK;
              end
            end
          end
          PH_ALL: begin
            if (add_byte(b, SECT_ALL, blk_len)) begin
              if (running != 0) halt(RPL_SUM_ERR, ERR_ALL_SUM);
              else begin
                ph = PH_DONE;
                now.reply_code = RPL_ACK;
              end
            end
          end
          default: ;
        endcase
      end
      now.finished = (ph == PH_DONE);
      now.long_wait = wait_long;
      now.transfer_kind = kind;
      now.mode_value = mode;
      now.payload_size = blk_len;
      due_replies.push_back(now);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_reply(logic [TDATA_W-1:0] data);
      result_t got, want;
      got = result_t'(data[RESULT_W-1:0]);
      if (due_replies.size() == 0) begin
        $error("result with none pending: %h", data);
        mismatches++;
        return;
      end
      want = due_replies.pop_front();
      compare_field("reply_code", want.reply_code, got.reply_code);
      compare_field("error_kind", want.error_kind, got.error_kind);
      compare_field("finished", want.finished, got.finished);
      compare_field("long_wait", want.long_wait, got.long_wait);
      compare_field("payload_valid", want.payload_valid, got.payload_valid);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_section", want.payload_section, got.payload_section);
      compare_field("transfer_kind", want.transfer_kind, got.transfer_kind);
      compare_field("mode_value", want.mode_value, got.mode_value);
      compare_field("payload_size", want.payload_size, got.payload_size);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;

  link_session_tracker tracker;
  int                  burst_left = 0;
  int                  sent_items = 0;
  int                  cycle_count = 0;
  int                  ready_run = 0;
  int                  ready_mode = 0;
  logic [7:0]          lead_bytes [6];

  link_receiver_protocol_fsm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) tracker.take_rx(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.match_reply(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      ready_run = $urandom_range(1, 48);
      ready_mode = $urandom_range(0, 3);
    end else begin
      ready_run--;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_item(input logic tmo, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    sent_items++;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= tmo;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // bytes after the start byte; the last one closes the zero sum unless good is clear
  task automatic push_block(input int n_lead, input int n, input bit good, input bit noisy,
                            input int tmo_at);
    logic [7:0] total;
    logic [7:0] b;
    total = '0;
    for (int i = 0; i < n; i++) begin
      if (i == tmo_at || (noisy && $urandom_range(0, 15) == 0)) push_item(1'b1, 8'($urandom));
      if (i < n_lead) b = lead_bytes[i];
      else if (i == n - 1) b = good ? -total : -total + 8'($urandom_range(1, 255));
      else b = 8'($urandom);
      total = total + b;
      push_item(1'b0, b);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.taken != sent_items || tracker.due_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.configure(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int          pick;
    int          variant;
    int          tmo_at;
    int          h;
    int          w;
    logic [15:0] len;
    logic [7:0]  code;
    logic [1:0]  plan_kind;
    bit          overwrite_step;
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pick = $urandom_range(0, 9);
    plan_kind = (pick < 5) ? KIND_ALL : ((pick < 8) ? KIND_ONE : KIND_SCR);
    overwrite_step = (plan_kind != KIND_SCR) && ($urandom_range(0, 3) != 0);
    variant = $urandom_range(0, 3);

    write_reg(CFG_SYNC, 8'hFF);
    write_reg(CFG_SYNC, 8'h00);
    write_reg(CFG_START, 8'hFF);
    write_reg(CFG_ACK, 8'h00);
    write_reg(CFG_NAK, 8'hFF);
    write_reg(CFG_EXISTS, 8'(overwrite_step));

    push_item(1'b1, 8'hFF);
    push_item(1'b1, 8'h00);
    push_item(1'b0, 8'h00);
    settle();

    if (plan_kind == KIND_SCR) begin
      h = $urandom_range(100, 130);
      w = $urandom_range(100, 130);
      len = 16'(h * w / 8 + 2);
      lead_bytes = '{CHR_D, CHR_D, 8'(h), 8'(w), 8'($urandom), 8'($urandom)};
    end else begin
      len = 16'($urandom_range(1300, 1500));
      lead_bytes = '{CHR_P, (plan_kind == KIND_ALL) ? CHR_Z : CHR_1, 8'($urandom),
                     len[15:8], len[7:0], 8'($urandom)};
    end
    code = 8'($urandom);
    write_reg(CFG_START, code);
    push_item(1'b0, code);
    push_block(6, HEADER_LEN - 1, 1'b1, 1'b0, -1);
    settle();

    if (overwrite_step) begin
      code = 8'($urandom);
      write_reg(CFG_ACK, code);
      write_reg(CFG_NAK, code);
      push_item(1'b1, 8'($urandom));
      push_item(1'b0, code);
      settle();
    end

    write_reg(CFG_START, 8'h00);
    push_item(1'b0, 8'h00);
    if (plan_kind == KIND_ALL) begin
      push_block(0, DIRECTORY_LEN - 1, 1'b1, 1'b0, -1);
      settle();
      write_reg(CFG_START, 8'hFF);
      push_item(1'b0, 8'hFF);
    end
    if (variant == 3) tmo_at = $urandom_range(0, len - 2);
    else tmo_at = -1;
    push_block(0, len - 1, variant != 2, plan_kind == KIND_SCR, tmo_at);
    settle();

    write_reg(CFG_EXISTS, 8'(!overwrite_step));
    write_reg(CFG_SYNC, 8'($urandom));
    repeat (20) push_item(1'($urandom_range(0, 1)), 8'($urandom));
    settle();
    repeat (4) @(posedge clk_i);

    if (tracker.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
